// File: design/vvpbc_pkg.sv
// ----------------------------------------------------------------------------
// vvpbc_pkg
// Shared widths, types and helpers of the velocity Verlet update core.
// ----------------------------------------------------------------------------
package vvpbc_pkg;

    // field and register widths
    localparam int DATA_W    = 32;
    localparam int DT_W      = 24;
    localparam int LEN_W     = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_ADDR_W = 2;
    localparam int NUM_AXES  = 3;

    // internal arithmetic widths
    localparam int PROD_W = DATA_W + DT_W + 1;   // signed 32 x unsigned 24
    localparam int SUM_W  = PROD_W + 1;          // v*dt + h*dt
    localparam int Q_W    = SUM_W + 1;           // p + shifted drift
    localparam int ADJ_W  = Q_W + 1;             // 2q and wrapped q

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TIME_STEP = 2'd0,
        CFG_BOX_LEN_X = 2'd1,
        CFG_BOX_LEN_Y = 2'd2,
        CFG_BOX_LEN_Z = 2'd3
    } cfg_idx_t;

    // request mode codes
    localparam logic REQ_DRIFT = 1'b0;
    localparam logic REQ_KICK  = 1'b1;

    // control carried beside the lanes
    typedef struct packed {
        logic valid;
        logic drift;
        logic last;
    } stage_ctrl_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic [ADJ_W-1:0]  q_wrap;
        logic [DATA_W-1:0] pos;
        logic [DATA_W-1:0] vel;
    } lane_res_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic [DATA_W-1:0] sat32(input logic [ADJ_W-1:0] x);
        logic all_zero;
        logic all_one;
        all_zero = ~|x[ADJ_W-1:DATA_W-1];
        all_one  = &x[ADJ_W-1:DATA_W-1];
        if (all_zero || all_one)
            return x[DATA_W-1:0];
        else if (x[ADJ_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

// File: design/vvpbc_atom_if.sv
// ----------------------------------------------------------------------------
// vvpbc_atom_if
// Request channel: one atom's state and mode per request.
// ----------------------------------------------------------------------------
interface vvpbc_atom_if
    import vvpbc_pkg::*;
();

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] pos_y;
    logic [DATA_W-1:0] pos_z;
    logic [DATA_W-1:0] vel_x;
    logic [DATA_W-1:0] vel_y;
    logic [DATA_W-1:0] vel_z;
    logic [DATA_W-1:0] acc_x;
    logic [DATA_W-1:0] acc_y;
    logic [DATA_W-1:0] acc_z;
    logic              last_atom;

    modport source (
        output valid, req_type, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               acc_x, acc_y, acc_z, last_atom,
        input  ready
    );

    modport sink (
        input  valid, req_type, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               acc_x, acc_y, acc_z, last_atom,
        output ready
    );

endinterface

// File: design/vvpbc_update_if.sv
// ----------------------------------------------------------------------------
// vvpbc_update_if
// Result channel: updated position and velocity of one atom per request.
// ----------------------------------------------------------------------------
interface vvpbc_update_if
    import vvpbc_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] new_pos_x;
    logic [DATA_W-1:0] new_pos_y;
    logic [DATA_W-1:0] new_pos_z;
    logic [DATA_W-1:0] new_vel_x;
    logic [DATA_W-1:0] new_vel_y;
    logic [DATA_W-1:0] new_vel_z;
    logic              sweep_end;

    modport source (
        output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, sweep_end,
        input  ready
    );

    modport sink (
        input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, sweep_end,
        output ready
    );

endinterface

// File: design/vvpbc_lane.sv
// ----------------------------------------------------------------------------
// vvpbc_lane
// One axis of the update: half kick, drift and single periodic wrap,
// seven register stages advanced together by a shared enable.
// ----------------------------------------------------------------------------
module vvpbc_lane
    import vvpbc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              en,
    input  logic [DT_W-1:0]   dt,
    input  logic [LEN_W-1:0]  box_len,
    input  logic [DATA_W-1:0] pos,
    input  logic [DATA_W-1:0] vel,
    input  logic [DATA_W-1:0] acc,
    output lane_res_t         res
);

    // stage 1: a*dt
    logic signed [PROD_W-1:0] s1_prod_reg, s1_prod_next;
    logic [DATA_W-1:0]        s1_pos_reg, s1_vel_reg;
    // stage 2: half kick
    logic [DATA_W-1:0]        s2_h_reg, s2_h_next;
    logic [DATA_W-1:0]        s2_pos_reg, s2_vel_reg;
    // stage 3: v*dt, h*dt and new velocity
    logic signed [PROD_W-1:0] s3_vdt_reg, s3_vdt_next;
    logic signed [PROD_W-1:0] s3_hdt_reg, s3_hdt_next;
    logic [DATA_W-1:0]        s3_vel_reg, s3_vel_next;
    logic [DATA_W-1:0]        s3_pos_reg;
    // stage 4: drift sum
    logic signed [SUM_W-1:0]  s4_sum_reg, s4_sum_next;
    logic [DATA_W-1:0]        s4_pos_reg, s4_vel_reg;
    // stage 5: moved position
    logic signed [Q_W-1:0]    s5_q_reg, s5_q_next;
    logic [DATA_W-1:0]        s5_pos_reg, s5_vel_reg;
    // stage 6: wrap decision
    logic signed [Q_W-1:0]    s6_q_reg;
    logic                     s6_ge_reg, s6_ge_next;
    logic                     s6_lt_reg, s6_lt_next;
    logic [DATA_W-1:0]        s6_pos_reg, s6_vel_reg;
    // stage 7: wrapped position
    lane_res_t                s7_res_reg, s7_res_next;

    logic signed [PROD_W-1:0] h_shift;
    logic signed [DATA_W:0]   v_plus_h;
    logic signed [SUM_W-1:0]  sum_shift;
    logic signed [ADJ_W-1:0]  q_twice;
    logic signed [ADJ_W-1:0]  len_ext;
    logic signed [ADJ_W-1:0]  q_ext;

    assign len_ext = $signed({{(ADJ_W-LEN_W){1'b0}}, box_len});

    // stage 1 product
    always_comb
    begin
        s1_prod_next = $signed(acc) * $signed({1'b0, dt});
    end

    // stage 2 floor shift and clamp
    always_comb
    begin
        h_shift   = s1_prod_reg >>> (FRAC_BITS + 1);
        s2_h_next = sat32({{(ADJ_W-PROD_W){h_shift[PROD_W-1]}}, h_shift});
    end

    // stage 3 products and velocity kick
    always_comb
    begin
        s3_vdt_next = $signed(s2_vel_reg) * $signed({1'b0, dt});
        s3_hdt_next = $signed(s2_h_reg) * $signed({1'b0, dt});
        v_plus_h    = $signed({s2_vel_reg[DATA_W-1], s2_vel_reg})
                    + $signed({s2_h_reg[DATA_W-1], s2_h_reg});
        s3_vel_next = sat32({{(ADJ_W-DATA_W-1){v_plus_h[DATA_W]}}, v_plus_h});
    end

    // stage 4 drift sum
    always_comb
    begin
        s4_sum_next = $signed({s3_vdt_reg[PROD_W-1], s3_vdt_reg})
                    + $signed({s3_hdt_reg[PROD_W-1], s3_hdt_reg});
    end

    // stage 5 scale drift and move
    always_comb
    begin
        sum_shift = s4_sum_reg >>> FRAC_BITS;
        s5_q_next = $signed({{(Q_W-DATA_W){s4_pos_reg[DATA_W-1]}}, s4_pos_reg})
                  + $signed({sum_shift[SUM_W-1], sum_shift});
    end

    // stage 6 compare 2q with the half-open box
    always_comb
    begin
        q_twice    = $signed({s5_q_reg, 1'b0});
        s6_ge_next = (q_twice >= len_ext);
        s6_lt_next = (q_twice < -len_ext);
    end

    // stage 7 single wrap
    always_comb
    begin
        q_ext = $signed({s6_q_reg[Q_W-1], s6_q_reg});
        if (s6_ge_reg)
            s7_res_next.q_wrap = q_ext - len_ext;
        else if (s6_lt_reg)
            s7_res_next.q_wrap = q_ext + len_ext;
        else
            s7_res_next.q_wrap = q_ext;
        s7_res_next.pos = s6_pos_reg;
        s7_res_next.vel = s6_vel_reg;
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_pos_reg  <= pos;
            s1_vel_reg  <= vel;

            s2_h_reg    <= s2_h_next;
            s2_pos_reg  <= s1_pos_reg;
            s2_vel_reg  <= s1_vel_reg;

            s3_vdt_reg  <= s3_vdt_next;
            s3_hdt_reg  <= s3_hdt_next;
            s3_vel_reg  <= s3_vel_next;
            s3_pos_reg  <= s2_pos_reg;

            s4_sum_reg  <= s4_sum_next;
            s4_pos_reg  <= s3_pos_reg;
            s4_vel_reg  <= s3_vel_reg;

            s5_q_reg    <= s5_q_next;
            s5_pos_reg  <= s4_pos_reg;
            s5_vel_reg  <= s4_vel_reg;

            s6_q_reg    <= s5_q_reg;
            s6_ge_reg   <= s6_ge_next;
            s6_lt_reg   <= s6_lt_next;
            s6_pos_reg  <= s5_pos_reg;
            s6_vel_reg  <= s5_vel_reg;

            s7_res_reg  <= s7_res_next;
        end
    end

    assign res = s7_res_reg;

endmodule

// File: design/vvpbc_merge.sv
// ----------------------------------------------------------------------------
// vvpbc_merge
// Combines the three lanes into one result: final clamp, kick-mode
// position pass-through and the output register with its stall enable.
// ----------------------------------------------------------------------------
module vvpbc_merge
    import vvpbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stage_ctrl_t           ctrl,
    input  lane_res_t             lanes [NUM_AXES],
    output logic                  en,
    vvpbc_update_if.source        update
);

    logic              out_valid_reg;
    logic              out_last_reg;
    logic [DATA_W-1:0] out_pos_reg  [NUM_AXES];
    logic [DATA_W-1:0] out_vel_reg  [NUM_AXES];
    logic [DATA_W-1:0] out_pos_next [NUM_AXES];

    // whole pipeline moves when the output register is free or drained
    assign en = !out_valid_reg || update.ready;

    // clamp drifted positions, keep the input position on a kick
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (ctrl.drift)
                out_pos_next[i] = sat32(lanes[i].q_wrap);
            else
                out_pos_next[i] = lanes[i].pos;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ctrl.valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_last_reg <= ctrl.last;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                out_pos_reg[i] <= out_pos_next[i];
                out_vel_reg[i] <= lanes[i].vel;
            end
        end
    end

    assign update.valid     = out_valid_reg;
    assign update.new_pos_x = out_pos_reg[0];
    assign update.new_pos_y = out_pos_reg[1];
    assign update.new_pos_z = out_pos_reg[2];
    assign update.new_vel_x = out_vel_reg[0];
    assign update.new_vel_y = out_vel_reg[1];
    assign update.new_vel_z = out_vel_reg[2];
    assign update.sweep_end = out_last_reg;

endmodule

// File: design/velocity_verlet_pbc_update_core.sv
// ----------------------------------------------------------------------------
// velocity_verlet_pbc_update_core
// Per-atom velocity Verlet update with a single periodic wrap per axis,
// signed fixed point with saturation; one lane per axis.
//
//   channel  | dir | handshake        | contents
//   ---------+-----+------------------+-----------------------------------
//   atom     | in  | valid / ready    | mode, pos, vel, acc (x,y,z), last
//   update   | out | valid / ready    | new pos, new vel (x,y,z), sweep end
//   cfg      | in  | cfg_we           | cfg_addr index, cfg_wdata value
//
// One request per cycle unless stalled; a result passes through the seven
// lane stages and then the output register.
// The pipeline stalls as a whole while the output register holds an
// unaccepted result; atom.ready is that stall enable.
// Reset clears stage valids, the output valid and all config registers.
// ----------------------------------------------------------------------------
module velocity_verlet_pbc_update_core
    import vvpbc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    vvpbc_atom_if.sink            atom,
    vvpbc_update_if.source        update
);

    localparam int STAGES = 7;

    logic [DT_W-1:0]   time_step_reg;
    logic [LEN_W-1:0]  box_len_reg [NUM_AXES];
    stage_ctrl_t       ctrl_reg    [STAGES];
    stage_ctrl_t       ctrl_next;
    logic [STAGES-1:0] stage_valid;
    logic              en;
    logic [DATA_W-1:0] pos_in [NUM_AXES];
    logic [DATA_W-1:0] vel_in [NUM_AXES];
    logic [DATA_W-1:0] acc_in [NUM_AXES];
    lane_res_t         lane_res [NUM_AXES];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++)
                box_len_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_TIME_STEP: time_step_reg  <= cfg_wdata[DT_W-1:0];
                CFG_BOX_LEN_X: box_len_reg[0] <= cfg_wdata[LEN_W-1:0];
                CFG_BOX_LEN_Y: box_len_reg[1] <= cfg_wdata[LEN_W-1:0];
                CFG_BOX_LEN_Z: box_len_reg[2] <= cfg_wdata[LEN_W-1:0];
            endcase
        end
    end

    assign atom.ready = en;

    // request control entering the pipeline
    always_comb
    begin
        ctrl_next.valid = atom.valid;
        ctrl_next.drift = (atom.req_type == REQ_DRIFT);
        ctrl_next.last  = atom.last_atom;
    end

    // control shift line beside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
                ctrl_reg[i] <= '0;
        end
        else if (en)
        begin
            ctrl_reg[0] <= ctrl_next;
            for (int i = 1; i < STAGES; i++)
                ctrl_reg[i] <= ctrl_reg[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
            stage_valid[i] = ctrl_reg[i].valid;
    end

    // per-axis operands
    assign pos_in[0] = atom.pos_x;
    assign pos_in[1] = atom.pos_y;
    assign pos_in[2] = atom.pos_z;
    assign vel_in[0] = atom.vel_x;
    assign vel_in[1] = atom.vel_y;
    assign vel_in[2] = atom.vel_z;
    assign acc_in[0] = atom.acc_x;
    assign acc_in[1] = atom.acc_y;
    assign acc_in[2] = atom.acc_z;

    // one lane per axis
    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        vvpbc_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .dt      (time_step_reg),
            .box_len (box_len_reg[g]),
            .pos     (pos_in[g]),
            .vel     (vel_in[g]),
            .acc     (acc_in[g]),
            .res     (lane_res[g])
        );
    end

    // merge lanes into the output register
    vvpbc_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl_reg[STAGES-1]),
        .lanes  (lane_res),
        .en     (en),
        .update (update)
    );

    // a stalled pipeline keeps its occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stage_valid))
        else $error("stage valids moved during stall");

    // an accepted request occupies the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (atom.valid && atom.ready) |=> stage_valid[0])
        else $error("accepted request lost at entry");

    // the last stage lands in the output register with its marker
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && stage_valid[STAGES-1]) |=>
            (update.valid && update.sweep_end == $past(ctrl_reg[STAGES-1].last)))
        else $error("result not delivered from last stage");

    // back-pressure only comes from a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !atom.ready |-> update.valid)
        else $error("request stalled with empty output");

endmodule

// File: bench/vvpbc_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vvpbc_update_checker
// Watches the config port and both channels of the update core, works out
// each atom's new position and velocity as requests are accepted, and
// compares every accepted update against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module vvpbc_update_checker
    import vvpbc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    vvpbc_atom_if                 atom,
    vvpbc_update_if               update,
    output int                    pending,
    output int                    errors
);

    typedef logic [NUM_AXES-1:0][DATA_W-1:0] axis_words_t;

    typedef struct packed {
        axis_words_t pos;
        axis_words_t vel;
        logic        sweep_end;
    } atom_update_t;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    // shadow copy of the configuration registers
    logic [DT_W-1:0]  step_r;
    logic [LEN_W-1:0] box_len [NUM_AXES];

    // predicted updates, oldest first
    atom_update_t     update_q [$];

    function automatic longint clamp_word(input longint x);
        if (x > WORD_MAX)
            return WORD_MAX;
        if (x < WORD_MIN)
            return WORD_MIN;
        return x;
    endfunction

    // one axis: half kick, optional drift with a single periodic wrap
    function automatic void advance_axis(
        input  logic              drift,
        input  logic [DATA_W-1:0] p_in,
        input  logic [DATA_W-1:0] v_in,
        input  logic [DATA_W-1:0] a_in,
        input  logic [LEN_W-1:0]  len_in,
        output logic [DATA_W-1:0] p_out,
        output logic [DATA_W-1:0] v_out
    );
        longint p;
        longint v;
        longint a;
        longint dt;
        longint len;
        longint kick;
        longint q;
        p    = longint'($signed(p_in));
        v    = longint'($signed(v_in));
        a    = longint'($signed(a_in));
        dt   = longint'(step_r);
        len  = longint'(len_in);
        kick = clamp_word((a * dt) >>> (FRAC_BITS + 1));
        if (drift)
        begin
            q = p + ((v * dt + kick * dt) >>> FRAC_BITS);
            if (2 * q >= len)
                q = q - len;
            else if (2 * q < -len)
                q = q + len;
            p_out = DATA_W'(clamp_word(q));
        end
        else
        begin
            p_out = p_in;
        end
        v_out = DATA_W'(clamp_word(v + kick));
    endfunction

    function automatic atom_update_t predict_update(
        input logic        mode,
        input axis_words_t pos,
        input axis_words_t vel,
        input axis_words_t acc,
        input logic        last
    );
        atom_update_t      r;
        logic [DATA_W-1:0] p_new;
        logic [DATA_W-1:0] v_new;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            advance_axis(mode == REQ_DRIFT, pos[i], vel[i], acc[i], box_len[i], p_new, v_new);
            r.pos[i] = p_new;
            r.vel[i] = v_new;
        end
        r.sweep_end = last;
        return r;
    endfunction

    task automatic check_word(input string what, input int axis,
                              input logic [DATA_W-1:0] want, input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            if (errors < 10)
                $display("update mismatch on %s[%0d]: expected %h got %h", what, axis, want, got);
            errors++;
        end
    endtask

    // track config, predict on accepted requests, compare accepted updates
    always @(posedge clk or negedge rst_n)
    begin
        atom_update_t want;
        if (!rst_n)
        begin
            step_r = '0;
            for (int i = 0; i < NUM_AXES; i++)
                box_len[i] = '0;
            update_q.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_TIME_STEP: step_r     = cfg_wdata[DT_W-1:0];
                    CFG_BOX_LEN_X: box_len[0] = cfg_wdata[LEN_W-1:0];
                    CFG_BOX_LEN_Y: box_len[1] = cfg_wdata[LEN_W-1:0];
                    CFG_BOX_LEN_Z: box_len[2] = cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end

            if (atom.valid && atom.ready)
                update_q.push_back(predict_update(atom.req_type,
                    {atom.pos_z, atom.pos_y, atom.pos_x},
                    {atom.vel_z, atom.vel_y, atom.vel_x},
                    {atom.acc_z, atom.acc_y, atom.acc_x},
                    atom.last_atom));

            if (update.valid && update.ready)
            begin
                if (update_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("update with no request outstanding: pos %h %h %h",
                                 update.new_pos_x, update.new_pos_y, update.new_pos_z);
                    errors++;
                end
                else
                begin
                    want = update_q.pop_front();
                    check_word("new_pos", 0, want.pos[0], update.new_pos_x);
                    check_word("new_pos", 1, want.pos[1], update.new_pos_y);
                    check_word("new_pos", 2, want.pos[2], update.new_pos_z);
                    check_word("new_vel", 0, want.vel[0], update.new_vel_x);
                    check_word("new_vel", 1, want.vel[1], update.new_vel_y);
                    check_word("new_vel", 2, want.vel[2], update.new_vel_z);
                    check_word("sweep_end", 0, DATA_W'(want.sweep_end),
                               DATA_W'(update.sweep_end));
                end
            end

            pending = update_q.size();
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the velocity Verlet update core: directed
// boundary and saturation requests under fixed settings, then random atoms
// near the box edges under a series of random settings, with random gaps,
// back pressure, a long receiver hold-off and a full drain mid-phase.
// ----------------------------------------------------------------------------
module tb;
    import vvpbc_pkg::*;

    localparam int FRAC  = 16;
    localparam int UNIT  = 1 << FRAC;
    localparam logic [DATA_W-1:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] W_MIN = 32'h8000_0000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ATOMS   = 153;

    typedef struct packed {
        logic                            mode;
        logic [NUM_AXES-1:0][DATA_W-1:0] pos;
        logic [NUM_AXES-1:0][DATA_W-1:0] vel;
        logic [NUM_AXES-1:0][DATA_W-1:0] acc;
        logic                            last;
    } atom_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    int                    pending;
    int                    errors;

    // idling knobs shared by the request and update sides
    int                    gap_max;
    int                    stall_max;
    int                    rx_hold;

    // current settings, used to aim positions at the box edges
    logic [LEN_W-1:0]      cur_len [NUM_AXES];
    int                    n_drift;
    int                    n_kick;
    int                    n_settings;

    vvpbc_atom_if   atom ();
    vvpbc_update_if update ();

    velocity_verlet_pbc_update_core #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .atom      (atom),
        .update    (update)
    );

    vvpbc_update_checker #(
        .FRAC_BITS(FRAC)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .atom      (atom),
        .update    (update),
        .pending   (pending),
        .errors    (errors)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #12_000_000;
        $display("timeout with %0d updates outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic atom_req_t mk(input logic mode, input logic [DATA_W-1:0] p,
                                     input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] a,
                                     input logic last);
        atom_req_t r;
        r.mode = mode;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            r.pos[i] = p;
            r.vel[i] = v;
            r.acc[i] = a;
        end
        r.last = last;
        return r;
    endfunction

    // mostly moderate signed values, sometimes corners or any bit pattern
    function automatic logic [DATA_W-1:0] pick_word(input int unsigned span);
        longint mag;
        case ($urandom_range(0, 11))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       return W_MIN;
                    1:       return W_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return 32'd1;
                endcase
            end
            default:
            begin
                mag = longint'($urandom_range(0, span));
                return $urandom_range(0, 1) ? DATA_W'(-mag) : DATA_W'(mag);
            end
        endcase
    endfunction

    // positions close to either wrap edge or spread over the box
    function automatic logic [DATA_W-1:0] pick_pos(input logic [LEN_W-1:0] len);
        longint half;
        longint off;
        half = longint'(len) / 2;
        off  = longint'($urandom_range(0, 8192)) - 4096;
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1, 2:    return DATA_W'(half + off);
            3:       return DATA_W'(-half + off);
            default: return DATA_W'(longint'($urandom_range(0, len)) - half);
        endcase
    endfunction

    function automatic atom_req_t random_atom();
        atom_req_t r;
        r.mode = ($urandom_range(0, 3) == 0) ? REQ_KICK : REQ_DRIFT;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            r.pos[i] = pick_pos(cur_len[i]);
            r.vel[i] = pick_word(8 * UNIT);
            r.acc[i] = pick_word(8 * UNIT);
        end
        r.last = ($urandom_range(0, 15) == 0);
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LEN_W'(1);
            2:       return '1;
            3:       return LEN_W'($urandom_range(1, 64) * UNIT);
            default: return LEN_W'($urandom);
        endcase
    endfunction

    // one request: optional gap with valid low, then hold until accepted
    task automatic send_atom(input atom_req_t r);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            atom.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        atom.valid     <= 1'b1;
        atom.req_type  <= r.mode;
        atom.pos_x     <= r.pos[0];
        atom.pos_y     <= r.pos[1];
        atom.pos_z     <= r.pos[2];
        atom.vel_x     <= r.vel[0];
        atom.vel_y     <= r.vel[1];
        atom.vel_z     <= r.vel[2];
        atom.acc_x     <= r.acc[0];
        atom.acc_y     <= r.acc[1];
        atom.acc_z     <= r.acc[2];
        atom.last_atom <= r.last;
        do @(posedge clk); while (!atom.ready);
        if (r.mode == REQ_DRIFT)
            n_drift++;
        else
            n_kick++;
    endtask

    // stop offering and wait until every predicted update has come back
    task automatic drain();
        atom.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // write all four registers on consecutive edges, block idle
    task automatic program_block(input logic [DT_W-1:0] dt, input logic [LEN_W-1:0] lx,
                                 input logic [LEN_W-1:0] ly, input logic [LEN_W-1:0] lz);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TIME_STEP;
        cfg_wdata <= CFG_W'(dt);
        @(posedge clk);
        cfg_addr  <= CFG_BOX_LEN_X;
        cfg_wdata <= CFG_W'(lx);
        @(posedge clk);
        cfg_addr  <= CFG_BOX_LEN_Y;
        cfg_wdata <= CFG_W'(ly);
        @(posedge clk);
        cfg_addr  <= CFG_BOX_LEN_Z;
        cfg_wdata <= CFG_W'(lz);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_len[0] = lx;
        cur_len[1] = ly;
        cur_len[2] = lz;
        n_settings++;
    endtask

    // update side: random stalls per update, plus an occasional long hold-off
    initial
    begin
        int stall;
        update.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                update.ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                update.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            update.ready <= 1'b1;
            do @(posedge clk); while (!update.valid);
        end
    end

    // request side and verdict
    initial
    begin
        logic [DT_W-1:0] dt;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_TIME_STEP;
        cfg_wdata      = '0;
        atom.valid     = 1'b0;
        atom.req_type  = REQ_DRIFT;
        atom.pos_x     = '0;
        atom.pos_y     = '0;
        atom.pos_z     = '0;
        atom.vel_x     = '0;
        atom.vel_y     = '0;
        atom.vel_z     = '0;
        atom.acc_x     = '0;
        atom.acc_y     = '0;
        atom.acc_z     = '0;
        atom.last_atom = 1'b0;
        gap_max        = 14;
        stall_max      = 14;
        rx_hold        = 0;
        n_drift        = 0;
        n_kick         = 0;
        n_settings     = 1;
        for (int i = 0; i < NUM_AXES; i++)
            cur_len[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero step and zero box, values pass through
        send_atom(mk(REQ_DRIFT, W_MAX, W_MIN, W_MAX, 1'b1));
        send_atom(mk(REQ_KICK,  W_MIN, W_MAX, W_MIN, 1'b0));
        send_atom(mk(REQ_DRIFT, '0, '0, '0, 1'b0));
        send_atom(mk(REQ_DRIFT, '1, '1, '1, 1'b0));
        drain();

        // unit step, boxes of 10 and 20 units and one odd lsb box
        program_block(DT_W'(UNIT), LEN_W'(10 * UNIT), LEN_W'(20 * UNIT), LEN_W'(1));
        // landing exactly on +L/2 wraps, exactly on -L/2 stays, one lsb below wraps
        send_atom(mk(REQ_DRIFT, DATA_W'(4 * UNIT), DATA_W'(UNIT), '0, 1'b0));
        send_atom(mk(REQ_DRIFT, DATA_W'(-4 * UNIT), DATA_W'(-UNIT), '0, 1'b0));
        send_atom(mk(REQ_DRIFT, DATA_W'(-5 * UNIT), '1, '0, 1'b0));
        send_atom(mk(REQ_KICK, DATA_W'(5 * UNIT), DATA_W'(UNIT), DATA_W'(2 * UNIT), 1'b0));
        send_atom(mk(REQ_DRIFT, '0, '0, DATA_W'(4 * UNIT), 1'b0));
        send_atom(mk(REQ_DRIFT, W_MAX, W_MAX, W_MAX, 1'b0));
        send_atom(mk(REQ_DRIFT, W_MIN, W_MIN, W_MIN, 1'b0));
        // negative half kick rounds toward minus infinity
        send_atom(mk(REQ_DRIFT, DATA_W'(UNIT), '0, '1, 1'b1));
        drain();

        // largest step and largest boxes: saturation and huge drift
        program_block('1, '1, '1, '1);
        send_atom(mk(REQ_DRIFT, '0, '0, W_MAX, 1'b0));
        send_atom(mk(REQ_DRIFT, '0, W_MIN, W_MIN, 1'b0));
        send_atom(mk(REQ_KICK, W_MAX, '0, W_MAX, 1'b0));
        send_atom(mk(REQ_DRIFT, 32'h3FFF_FFFF, 32'd1, '0, 1'b0));
        send_atom(mk(REQ_DRIFT, W_MIN, W_MIN, '0, 1'b0));
        send_atom(mk(REQ_DRIFT, W_MAX, W_MAX, '0, 1'b1));
        drain();

        // random settings and atoms, idling pattern varies per phase
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            case (k % 5)
                0:       dt = DT_W'(655);
                1:       dt = DT_W'($urandom);
                2:       dt = DT_W'(UNIT);
                3:       dt = '1;
                default: dt = DT_W'($urandom_range(0, 4 * UNIT));
            endcase
            if (k == 4)
                dt = '0;
            program_block(dt, pick_len(), pick_len(), pick_len());

            case (k % 4)
                0:
                begin
                    gap_max   = 14;
                    stall_max = 14;
                end
                1:
                begin
                    gap_max   = 0;
                    stall_max = 0;
                end
                2:
                begin
                    gap_max   = 0;
                    stall_max = 14;
                end
                default:
                begin
                    gap_max   = 14;
                    stall_max = 0;
                end
            endcase
            // long hold-off so the pipeline fills and stalls the requests
            if (k == 2 || k == 6)
                rx_hold = 300;

            for (int i = 0; i < PHASE_ATOMS; i++)
            begin
                if ((k == 3 || k == 7) && i == PHASE_ATOMS / 2)
                    drain();
                send_atom(random_atom());
            end
            drain();
        end

        repeat (16) @(posedge clk);
        $display("sent %0d atoms (%0d drift, %0d kick) under %0d register settings",
                 n_drift + n_kick, n_drift, n_kick, n_settings);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
